// ===== rtl/efr_pkg.sv =====
// shared types and constants for the escaped frame receiver
package efr_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 9;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
   localparam logic [COUNT_W-1:0] LIMIT_MAX = 9'd510;
   localparam logic [BYTE_W-1:0]  GOOD_SUM  = 8'hFF;

   // reset values of the control registers
   localparam logic [BYTE_W-1:0]  START_RESET  = 8'd2;
   localparam logic [BYTE_W-1:0]  END_RESET    = 8'd3;
   localparam logic [BYTE_W-1:0]  ESCAPE_RESET = 8'd16;
   localparam logic [COUNT_W-1:0] LIMIT_RESET  = 9'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START  = 2'd0,
      CSR_END    = 2'd1,
      CSR_ESCAPE = 2'd2,
      CSR_LIMIT  = 2'd3
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA    = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_DISCARD = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PHASE_IDLE  = 3'b001,
      PHASE_FRAME = 3'b010,
      PHASE_ESC   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  start_code;
      logic [BYTE_W-1:0]  end_code;
      logic [BYTE_W-1:0]  escape_code;
      logic [COUNT_W-1:0] max_frame_length;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] payload;
      logic              error;
   } result_type;

endpackage

// ===== rtl/efr_if.sv =====
// valid/ready channel interfaces for received bytes and deframer results
interface efr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] payload_byte;
   logic       error_seen;

   modport source (output valid, output result_kind, output payload_byte,
                   output error_seen, input ready);
   modport sink (input valid, input result_kind, input payload_byte,
                 input error_seen, output ready);
endinterface

// ===== rtl/efr_core.sv =====
// deframing state and per-byte next-state and result logic
module efr_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [efr_pkg::BYTE_W-1:0]    rx_byte,
   input  efr_pkg::cfg_type              cfg,
   output efr_pkg::result_type           result
);
   import efr_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [BYTE_W-1:0]   held_ff, held_in;
   logic                held_valid_ff, held_valid_in;
   logic                error_ff, error_in;
   logic [COUNT_W-1:0]  limit;
   logic                do_accept, do_clear, do_discard, do_good;

   // a limit above the top value acts as the top value
   assign limit = (cfg.max_frame_length > LIMIT_MAX) ? LIMIT_MAX : cfg.max_frame_length;

   // classify the byte against the current phase
   always_comb begin
      phase_in   = phase_ff;
      do_accept  = 1'b0;
      do_clear   = 1'b0;
      do_discard = 1'b0;
      do_good    = 1'b0;
      unique case (phase_ff)
         PHASE_ESC: begin
            phase_in  = PHASE_FRAME;
            do_accept = 1'b1;
         end
         PHASE_FRAME: begin
            priority if (rx_byte == cfg.start_code) begin
               if (count_ff != '0) begin
                  do_discard = 1'b1;
               end else begin
                  do_clear = 1'b1;
               end
            end else if (rx_byte == cfg.escape_code) begin
               phase_in = PHASE_ESC;
            end else if (rx_byte == cfg.end_code) begin
               phase_in = PHASE_IDLE;
               if (sum_ff != GOOD_SUM) begin
                  do_discard = 1'b1;
               end else begin
                  do_clear = 1'b1;
                  do_good  = 1'b1;
               end
            end else if (count_ff > limit) begin
               do_discard = 1'b1;
            end else begin
               do_accept = 1'b1;
            end
         end
         default: begin
            phase_in = PHASE_IDLE;
            if (rx_byte == cfg.start_code) begin
               phase_in = PHASE_FRAME;
               do_clear = 1'b1;
            end
         end
      endcase
   end

   // frame counters, held byte and result
   always_comb begin
      count_in      = count_ff;
      sum_in        = sum_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      error_in      = error_ff;
      result.valid   = 1'b0;
      result.kind    = KIND_DATA;
      result.payload = '0;
      if (do_accept) begin
         held_in       = rx_byte;
         held_valid_in = 1'b1;
         count_in      = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
         sum_in        = sum_ff + rx_byte;
         result.valid   = held_valid_ff;
         result.payload = held_ff;
      end
      if (do_clear || do_discard) begin
         count_in      = '0;
         sum_in        = '0;
         held_in       = '0;
         held_valid_in = 1'b0;
      end
      if (do_discard) begin
         error_in     = 1'b1;
         result.valid = 1'b1;
         result.kind  = KIND_DISCARD;
      end
      if (do_good) begin
         result.valid = 1'b1;
         result.kind  = KIND_GOOD;
      end
      result.error = error_in;
   end

   // state update on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_IDLE;
         count_ff      <= '0;
         sum_ff        <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         error_ff      <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         error_ff      <= error_in;
      end
   end

endmodule

// ===== rtl/efr_out_reg.sv =====
// result register in front of the response channel
module efr_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  efr_pkg::result_type result,
   output logic                free,
   efr_rsp_if.source           rsp_bus
);
   import efr_pkg::*;

   logic                valid_ff, valid_in;
   kind_type            kind_ff;
   logic [BYTE_W-1:0]   payload_ff;
   logic                error_ff;

   // register can take a new beat when empty or draining this cycle
   assign free     = !valid_ff || rsp_bus.ready;
   assign valid_in = free ? (load && result.valid) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload captured only with a new result
   always_ff @(posedge clock) begin
      if (free && load && result.valid) begin
         kind_ff    <= result.kind;
         payload_ff <= result.payload;
         error_ff   <= result.error;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.result_kind  = kind_ff;
   assign rsp_bus.payload_byte = payload_ff;
   assign rsp_bus.error_seen   = error_ff;

endmodule

// ===== rtl/escaped_frame_receiver_top.sv =====
// STX/ETX/DLE deframer: input register, per-byte state logic, result register
// an accepted byte waits in the input register; the result it produces is then registered in the result register
// throughput: one byte per cycle while the result register has room, set by the state update loop
// a byte is accepted whenever the input register is empty or moving on
// reset: synchronous, active high; clears phase, counters, error flag and valids
module escaped_frame_receiver_top (
   input  logic                            clock,
   input  logic                            reset,
   efr_req_if.sink                         req_bus,
   efr_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [efr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [efr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import efr_pkg::*;

   cfg_type             cfg_ff;
   logic                in_valid_ff;
   logic [BYTE_W-1:0]   in_byte_ff;
   logic                out_free;
   logic                step;
   result_type          result;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code       <= START_RESET;
         cfg_ff.end_code         <= END_RESET;
         cfg_ff.escape_code      <= ESCAPE_RESET;
         cfg_ff.max_frame_length <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_START:  cfg_ff.start_code       <= csr_wdata[BYTE_W-1:0];
            CSR_END:    cfg_ff.end_code         <= csr_wdata[BYTE_W-1:0];
            CSR_ESCAPE: cfg_ff.escape_code      <= csr_wdata[BYTE_W-1:0];
            CSR_LIMIT:  cfg_ff.max_frame_length <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // input register advances whenever the result register has room
   assign step          = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.rx_byte;
      end
   end

   efr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   efr_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (step),
      .result  (result),
      .free    (out_free),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== dv/tb_escaped_frame_receiver_top.sv =====
// testbench for the escaped frame receiver: directed byte table, then random frames vs a predictor
module tb_escaped_frame_receiver_top;
   import efr_pkg::*;

   localparam int unsigned RANDOM_ITEMS  = 1600;
   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam int unsigned TIMEOUT_UNITS = 8_000_000;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] payload;
      logic              err;
   } frame_result_t;

   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_WRITE
   } row_op_t;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_SILENT,
      CHK_TYPED
   } row_check_t;

   typedef struct packed {
      row_op_t            op;
      csr_index_type      reg_index;
      logic [COUNT_W-1:0] value;
      row_check_t         check;
      kind_type           kind;
      logic [BYTE_W-1:0]  payload;
      logic               err;
   } stim_row_t;

   localparam frame_result_t NO_BEAT = '{KIND_DATA, 8'h00, 1'b0};

   // directed table, reset codes: start 02, end 03, escape 10
   localparam stim_row_t DIRECTED_ROWS [26] = '{
      '{ROW_BYTE,  CSR_START, 9'h000, CHK_SILENT, KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h002, CHK_SILENT, KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h002, CHK_SILENT, KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h010, CHK_SILENT, KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h002, CHK_SILENT, KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h010, CHK_SILENT, KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h003, CHK_TYPED,  KIND_DATA,    8'h02, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h0FF, CHK_TYPED,  KIND_DATA,    8'h03, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h0FB, CHK_TYPED,  KIND_DATA,    8'hFF, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h003, CHK_TYPED,  KIND_GOOD,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h002, CHK_SILENT, KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h000, CHK_SILENT, KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h003, CHK_TYPED,  KIND_DISCARD, 8'h00, 1'b1},
      '{ROW_BYTE,  CSR_START, 9'h002, CHK_MODEL,  KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h055, CHK_MODEL,  KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h002, CHK_TYPED,  KIND_DISCARD, 8'h00, 1'b1},
      '{ROW_BYTE,  CSR_START, 9'h0FF, CHK_MODEL,  KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h003, CHK_TYPED,  KIND_GOOD,    8'h00, 1'b1},
      '{ROW_WRITE, CSR_LIMIT, 9'h001, CHK_MODEL,  KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h002, CHK_MODEL,  KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h011, CHK_MODEL,  KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h022, CHK_MODEL,  KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h033, CHK_TYPED,  KIND_DISCARD, 8'h00, 1'b1},
      '{ROW_BYTE,  CSR_START, 9'h044, CHK_MODEL,  KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h0BB, CHK_MODEL,  KIND_DATA,    8'h00, 1'b0},
      '{ROW_BYTE,  CSR_START, 9'h003, CHK_MODEL,  KIND_DATA,    8'h00, 1'b0}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   efr_req_if req_bus ();
   efr_rsp_if rsp_bus ();

   escaped_frame_receiver_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the control registers and deframer state
   cfg_type            rx_cfg;
   phase_type          cur_phase;
   logic [COUNT_W-1:0] byte_count;
   logic [BYTE_W-1:0]  check_sum;
   logic [BYTE_W-1:0]  held_data;
   logic               held_ok;
   logic               sticky_err;

   frame_result_t predicted_results [$];
   int unsigned   mismatch_count;
   int unsigned   random_items;
   int unsigned   stall_left;
   bit            no_idle;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("escaped_frame_receiver_top verification failed");
      $finish;
   end

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned gap_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic int unsigned sender_gap();
      if (no_idle || $urandom_range(0, 99) < 60) return 0;
      return gap_length();
   endfunction

   function automatic void clear_frame();
      byte_count = '0;
      check_sum  = '0;
      held_data  = '0;
      held_ok    = 1'b0;
   endfunction

   function automatic bit drop_frame(output frame_result_t res);
      clear_frame();
      sticky_err = 1'b1;
      res = '{KIND_DISCARD, 8'h00, 1'b1};
      return 1'b1;
   endfunction

   // data byte: count it, add it to the sum, release the one held before it
   function automatic bit take_data(input logic [BYTE_W-1:0] b, output frame_result_t res);
      logic [BYTE_W-1:0] prev;
      bit                had;
      prev = held_data;
      had = held_ok;
      held_data = b;
      held_ok = 1'b1;
      if (byte_count < COUNT_MAX) byte_count = byte_count + 9'd1;
      check_sum = check_sum + b;
      res = '{KIND_DATA, prev, sticky_err};
      return had;
   endfunction

   // one received byte through the deframer; returns 1 when a beat is due
   function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output frame_result_t res);
      logic [COUNT_W-1:0] limit;
      res = NO_BEAT;
      limit = (rx_cfg.max_frame_length > LIMIT_MAX) ? LIMIT_MAX : rx_cfg.max_frame_length;
      if (cur_phase == PHASE_ESC) begin
         cur_phase = PHASE_FRAME;
         return take_data(b, res);
      end
      if (cur_phase != PHASE_FRAME) begin
         cur_phase = PHASE_IDLE;
         if (b == rx_cfg.start_code) begin
            clear_frame();
            cur_phase = PHASE_FRAME;
         end
         return 1'b0;
      end
      // start wins over escape, escape over end
      if (b == rx_cfg.start_code) begin
         if (byte_count != '0) return drop_frame(res);
         clear_frame();
         return 1'b0;
      end
      if (b == rx_cfg.escape_code) begin
         cur_phase = PHASE_ESC;
         return 1'b0;
      end
      if (b == rx_cfg.end_code) begin
         cur_phase = PHASE_IDLE;
         if (check_sum != GOOD_SUM) return drop_frame(res);
         clear_frame();
         res = '{KIND_GOOD, 8'h00, sticky_err};
         return 1'b1;
      end
      if (byte_count > limit) return drop_frame(res);
      return take_data(b, res);
   endfunction

   // drive one byte beat and record what it should produce
   task automatic send_byte(input logic [BYTE_W-1:0] b, input row_check_t check,
                            input frame_result_t typed);
      frame_result_t res;
      bit            hit;
      int unsigned   gap;
      gap = sender_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      hit = deframe_byte(b, res);
      if (check == CHK_TYPED) predicted_results.push_back(typed);
      else if (check == CHK_MODEL && hit) predicted_results.push_back(res);
   endtask

   // stop sending and wait for every expected beat plus the pipeline depth
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_START:  rx_cfg.start_code = value[BYTE_W-1:0];
         CSR_END:    rx_cfg.end_code = value[BYTE_W-1:0];
         CSR_ESCAPE: rx_cfg.escape_code = value[BYTE_W-1:0];
         default:    rx_cfg.max_frame_length = value;
      endcase
   endtask

   function automatic void stuff_byte(ref logic [BYTE_W-1:0] q [$], input logic [BYTE_W-1:0] d,
                                      input bit escape_all);
      if (escape_all || d == rx_cfg.start_code || d == rx_cfg.end_code ||
          d == rx_cfg.escape_code || $urandom_range(0, 99) < 5)
         q.push_back(rx_cfg.escape_code);
      q.push_back(d);
   endfunction

   // one frame: mostly well formed, some with a bad checksum, cut short or led by noise
   task automatic send_frame(input int len, input bit escape_all);
      logic [BYTE_W-1:0] wire_bytes [$];
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] d;
      int unsigned       style;
      int unsigned       n_send;
      style = $urandom_range(0, 99);
      sum = '0;
      if (style >= 90)
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom), CHK_MODEL, NO_BEAT);
      wire_bytes.push_back(rx_cfg.start_code);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0:       d = rx_cfg.start_code;
            1:       d = rx_cfg.end_code;
            2:       d = rx_cfg.escape_code;
            3:       d = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default: d = 8'($urandom);
         endcase
         sum = sum + d;
         stuff_byte(wire_bytes, d, escape_all);
      end
      d = GOOD_SUM - sum;
      if (style >= 65 && style < 80) d = d ^ 8'($urandom_range(1, 255));
      stuff_byte(wire_bytes, d, escape_all);
      n_send = wire_bytes.size();
      if (style >= 80 && style < 90) n_send = $urandom_range(1, wire_bytes.size());
      else begin
         wire_bytes.push_back(rx_cfg.end_code);
         n_send = wire_bytes.size();
      end
      for (int unsigned i = 0; i < n_send; i++) send_byte(wire_bytes[i], CHK_MODEL, NO_BEAT);
      random_items += n_send;
   endtask

   // result side: check each accepted beat, then pick the next ready value
   always @(posedge clock) begin : result_check
      frame_result_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (predicted_results.size() == 0) begin
            note_mismatch($sformatf("unexpected beat kind %0d payload %02h error %0b",
                                    rsp_bus.result_kind, rsp_bus.payload_byte,
                                    rsp_bus.error_seen));
         end else begin
            want = predicted_results.pop_front();
            if (rsp_bus.result_kind !== want.kind || rsp_bus.payload_byte !== want.payload ||
                rsp_bus.error_seen !== want.err)
               note_mismatch($sformatf("kind %0d/%0d payload %02h/%02h error %0b/%0b (exp/act)",
                                       want.kind, rsp_bus.result_kind, want.payload,
                                       rsp_bus.payload_byte, want.err, rsp_bus.error_seen));
         end
      end
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 99) < 25) stall_left = gap_length();
      end
   end

   initial begin : stimulus
      cfg_type           next;
      logic [3:0]        mask;
      logic [COUNT_W-1:0] lim;
      int                len;
      int unsigned       phase_no;
      int unsigned       r;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_START;
      csr_wdata       <= '0;
      mismatch_count = 0;
      random_items = 0;
      stall_left = 0;
      no_idle = 1'b0;
      rx_cfg = '{START_RESET, END_RESET, ESCAPE_RESET, LIMIT_RESET};
      cur_phase = PHASE_IDLE;
      clear_frame();
      sticky_err = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].op == ROW_WRITE) begin
            drain_results();
            write_register(DIRECTED_ROWS[i].reg_index, DIRECTED_ROWS[i].value);
            csr_we <= 1'b0;
         end else begin
            send_byte(DIRECTED_ROWS[i].value[BYTE_W-1:0], DIRECTED_ROWS[i].check,
                      '{DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].payload, DIRECTED_ROWS[i].err});
         end
      end

      // random phases, each with its own register setting
      phase_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         drain_results();
         next.start_code = 8'($urandom);
         next.end_code = 8'($urandom);
         next.escape_code = 8'($urandom);
         case ($urandom_range(0, 7))
            0:       next.escape_code = next.start_code;
            1:       next.end_code = next.escape_code;
            2:       next.end_code = next.start_code;
            default: ;
         endcase
         r = $urandom_range(0, 9);
         if (r < 6) next.max_frame_length = 9'($urandom_range(1, 40));
         else if (r == 6) next.max_frame_length = 9'($urandom_range(0, 1));
         else if (r == 7) next.max_frame_length = LIMIT_MAX;
         else if (r == 8) next.max_frame_length = COUNT_MAX;
         else next.max_frame_length = 9'($urandom_range(1, 510));
         // opening phases hit the register extremes and code collisions
         case (phase_no)
            0: next = '{8'h00, 8'hFF, 8'h80, COUNT_MAX};
            1: next = '{8'hFF, 8'h00, 8'h7E, LIMIT_MAX};
            2: next = '{8'h02, 8'h03, 8'h10, 9'd0};
            3: next = '{8'h5A, 8'hA5, 8'h5A, 9'd1};
            4: next = '{8'h01, 8'hC3, 8'hC3, 9'd12};
            5: next = '{8'h3C, 8'h3C, 8'hFF, 9'd8};
            default: ;
         endcase
         mask = (phase_no < 6) ? 4'hF : 4'($urandom_range(1, 15));
         if (mask[CSR_START])  write_register(CSR_START, {1'b0, next.start_code});
         if (mask[CSR_END])    write_register(CSR_END, {1'b0, next.end_code});
         if (mask[CSR_ESCAPE]) write_register(CSR_ESCAPE, {1'b0, next.escape_code});
         if (mask[CSR_LIMIT])  write_register(CSR_LIMIT, next.max_frame_length);
         csr_we <= 1'b0;
         no_idle = ($urandom_range(0, 3) == 0);
         // escaped bytes skip the length check, so this drives the count into saturation
         if (phase_no == 0) send_frame(515, 1'b1);
         repeat ($urandom_range(4, 12)) begin
            lim = (rx_cfg.max_frame_length > LIMIT_MAX) ? LIMIT_MAX : rx_cfg.max_frame_length;
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(0, 12);
            else if (r < 85) len = int'(lim) - 2 + int'($urandom_range(0, 3));
            else len = $urandom_range(13, 60);
            if (len < 0) len = 0;
            if (random_items < RANDOM_ITEMS) send_frame(len, $urandom_range(0, 9) == 0);
         end
         phase_no++;
      end

      drain_results();
      if (mismatch_count == 0 && predicted_results.size() == 0)
         $display("escaped_frame_receiver_top verification clean");
      else
         $display("escaped_frame_receiver_top verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/efr_pkg.sv
rtl/efr_if.sv
rtl/efr_core.sv
rtl/efr_out_reg.sv
rtl/escaped_frame_receiver_top.sv
dv/tb_escaped_frame_receiver_top.sv
